// File: rtl/core/dsml_pkg.sv
// shared types and constants for the distance sorted match list
`timescale 1ns / 1ps

package dsml_pkg;

  // default sizes
  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF    = 16;
  localparam int unsigned DIST_BITS_DEF  = 20;

  // distance reported past the fill count (1500.0 with 4 fraction bits)
  localparam int FAR_DIST = 24000;

  // request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  // per cell update control
  typedef struct packed {
    logic load;   // take the new entry
    logic shift;  // take the left neighbor's entry
  } cell_ctrl_t;

endpackage

// File: rtl/core/dsml_cell.sv
// one storage cell of the sorted insertion row
`timescale 1ns / 1ps

module dsml_cell #(
  parameter int unsigned ID_BITS   = dsml_pkg::ID_BITS_DEF,
  parameter int unsigned DIST_BITS = dsml_pkg::DIST_BITS_DEF,
  localparam int unsigned EntryW   = ID_BITS + 4 * DIST_BITS
) (
  input  logic                      clk_i,
  input  dsml_pkg::cell_ctrl_t      ctrl_i,
  input  logic                      valid_i,
  input  logic signed [DIST_BITS:0] mag_i,
  input  logic [EntryW-1:0]         new_i,
  input  logic [EntryW-1:0]         left_i,
  output logic [EntryW-1:0]         entry_o,
  output logic                      gt_o
);

  logic [EntryW-1:0]         entry_q;
  logic [EntryW-1:0]         entry_d;
  logic [DIST_BITS-1:0]      stored_dist;
  logic signed [DIST_BITS:0] dist_ext;

  // entry layout is {id, dist, dx, dy, dz}
  assign stored_dist = entry_q[4*DIST_BITS-1:3*DIST_BITS];
  assign dist_ext    = $signed({stored_dist[DIST_BITS-1], stored_dist});
  assign gt_o        = valid_i && (mag_i < dist_ext);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = left_i;
    end else if (ctrl_i.load) begin
      entry_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/core/distance_sorted_match_list.sv
// top level of the distance sorted match list
`timescale 1ns / 1ps

// channel | valid     | stall      | payload
// --------+-----------+------------+------------------------------------------------
// in      | in_valid_i| in_stall_o | req_type, cand_id, cand_dist, cand_dx/dy/dz, rank
// out     | out_valid_o| out_stall_i| entry_id, entry_dist, entry_dx/dy/dz,
//         |           |            | fill_count, was_inserted, lost_entry
//
// every cell compares its stored distance with the new magnitude in the same
// cycle, and a one-bit prefix chain picks the insert spot
// result appears in the cycle after the transfer in, from the output register
// a request is taken whenever the output register is empty or being drained
// reset clears the fill count and the output valid; cell contents stay undefined
// an out stall holds the result and stalls the input side

module distance_sorted_match_list #(
  parameter int unsigned LIST_DEPTH = dsml_pkg::LIST_DEPTH_DEF,
  parameter int unsigned ID_BITS    = dsml_pkg::ID_BITS_DEF,
  parameter int unsigned DIST_BITS  = dsml_pkg::DIST_BITS_DEF,
  localparam int unsigned CntW      = $clog2(LIST_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [ID_BITS-1:0]          cand_id_i,
  input  logic signed [DIST_BITS-1:0] cand_dist_i,
  input  logic signed [DIST_BITS-1:0] cand_dx_i,
  input  logic signed [DIST_BITS-1:0] cand_dy_i,
  input  logic signed [DIST_BITS-1:0] cand_dz_i,
  input  logic [7:0]                  rank_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [ID_BITS:0]     entry_id_o,
  output logic signed [DIST_BITS-1:0] entry_dist_o,
  output logic signed [DIST_BITS-1:0] entry_dx_o,
  output logic signed [DIST_BITS-1:0] entry_dy_o,
  output logic signed [DIST_BITS-1:0] entry_dz_o,
  output logic [CntW-1:0]             fill_count_o,
  output logic                        was_inserted_o,
  output logic                        lost_entry_o
);

  localparam int unsigned EntryW = ID_BITS + 4 * DIST_BITS;
  localparam int unsigned IdxW   = $clog2(LIST_DEPTH);
  localparam int unsigned CmpW   = (CntW > 8) ? CntW : 8;

  // handshake
  logic in_xfer;
  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  dsml_pkg::req_e req;
  assign req = dsml_pkg::req_e'(req_type_i);

  logic ins_go;
  assign ins_go = in_xfer && (req == dsml_pkg::REQ_INSERT);

  // fill count
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            full;
  assign full = (count_q == CntW'(LIST_DEPTH));

  // magnitude of the new distance, one bit wider so the most negative value fits
  logic signed [DIST_BITS:0] dist_ext;
  logic signed [DIST_BITS:0] mag;
  assign dist_ext = $signed({cand_dist_i[DIST_BITS-1], cand_dist_i});
  assign mag      = cand_dist_i[DIST_BITS-1] ? -dist_ext : dist_ext;

  logic [EntryW-1:0] new_entry;
  assign new_entry = {cand_id_i, cand_dist_i, cand_dx_i, cand_dy_i, cand_dz_i};

  // the row of cells
  logic [EntryW-1:0]      entries [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]  gt;
  logic [LIST_DEPTH:0]    found;   // some cell to the left sorts after the new entry

  assign found[0] = 1'b0;

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    dsml_pkg::cell_ctrl_t ctrl;
    logic                 valid;
    logic [EntryW-1:0]    left;

    assign valid = (CntW'(k) < count_q);
    assign found[k+1] = found[k] | gt[k];

    // the cell at the insert spot takes the new entry, the cells after it shift right
    assign ctrl.shift = ins_go && found[k];
    assign ctrl.load  = ins_go && !found[k] && (gt[k] || (count_q == CntW'(k)));

    if (k == 0) begin : g_head
      assign left = new_entry;
    end else begin : g_body
      assign left = entries[k-1];
    end

    dsml_cell #(
      .ID_BITS   (ID_BITS),
      .DIST_BITS (DIST_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .valid_i (valid),
      .mag_i   (mag),
      .new_i   (new_entry),
      .left_i  (left),
      .entry_o (entries[k]),
      .gt_o    (gt[k])
    );
  end

  // rank lookup
  logic              hit;
  logic [IdxW-1:0]   rd_idx;
  logic [EntryW-1:0] rd_entry;
  assign hit      = (CmpW'(rank_i) < CmpW'(count_q));
  assign rd_idx   = rank_i[IdxW-1:0];
  assign rd_entry = entries[rd_idx];

  // result assembly
  logic signed [ID_BITS:0]     id_d;
  logic signed [DIST_BITS-1:0] dist_d;
  logic signed [DIST_BITS-1:0] dx_d;
  logic signed [DIST_BITS-1:0] dy_d;
  logic signed [DIST_BITS-1:0] dz_d;
  logic                        ins_d;
  logic                        lost_d;

  always_comb begin
    count_d = count_q;
    id_d    = '0;
    dist_d  = '0;
    dx_d    = '0;
    dy_d    = '0;
    dz_d    = '0;
    ins_d   = 1'b0;
    lost_d  = 1'b0;
    case (req)
      dsml_pkg::REQ_INSERT: begin
        if (full) begin
          // full list: dropping the last entry only if the new one sorts before it
          lost_d = 1'b1;
          ins_d  = found[LIST_DEPTH];
        end else begin
          ins_d   = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      dsml_pkg::REQ_READ: begin
        if (hit) begin
          id_d   = $signed({1'b0, rd_entry[EntryW-1:4*DIST_BITS]});
          dist_d = rd_entry[4*DIST_BITS-1:3*DIST_BITS];
          dx_d   = rd_entry[3*DIST_BITS-1:2*DIST_BITS];
          dy_d   = rd_entry[2*DIST_BITS-1:DIST_BITS];
          dz_d   = rd_entry[DIST_BITS-1:0];
        end else begin
          id_d   = '1;
          dist_d = DIST_BITS'(dsml_pkg::FAR_DIST);
        end
      end
      dsml_pkg::REQ_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  logic signed [ID_BITS:0]     id_q;
  logic signed [DIST_BITS-1:0] dist_q;
  logic signed [DIST_BITS-1:0] dx_q;
  logic signed [DIST_BITS-1:0] dy_q;
  logic signed [DIST_BITS-1:0] dz_q;
  logic [CntW-1:0]             fill_q;
  logic                        ins_q;
  logic                        lost_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      id_q   <= id_d;
      dist_q <= dist_d;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dz_q   <= dz_d;
      fill_q <= count_d;
      ins_q  <= ins_d;
      lost_q <= lost_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign entry_id_o     = id_q;
  assign entry_dist_o   = dist_q;
  assign entry_dx_o     = dx_q;
  assign entry_dy_o     = dy_q;
  assign entry_dz_o     = dz_q;
  assign fill_count_o   = fill_q;
  assign was_inserted_o = ins_q;
  assign lost_entry_o   = lost_q;

endmodule
